### rtl/core/mcpg_pkg.sv
`default_nettype none

package mcpg_pkg;

    localparam int COORD_BITS_DEF  = 8;
    localparam int RADIUS_BITS_DEF = 5;
    localparam int CHAR_BITS       = 8;

    // Results per circle are capped; two results per walk point.
    localparam int RESULT_CAP = 48;
    localparam int POINT_CAP  = RESULT_CAP / 2;
    localparam int CNT_W      = $clog2(POINT_CAP);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic load;
        logic advance;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
    } dp_status_t;

endpackage

`default_nettype wire

### rtl/core/mcpg_ctrl.sv
`default_nettype none

module mcpg_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    output logic                     out_valid,
    input  wire logic                out_stall,
    input  wire mcpg_pkg::dp_status_t status,
    output mcpg_pkg::dp_cmd_t        cmd
);

    mcpg_pkg::state_t state_reg;
    mcpg_pkg::state_t state_next;
    logic             in_beat;
    logic             out_beat;

    assign in_beat  = in_valid && !in_stall;
    assign out_beat = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mcpg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mcpg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mcpg_pkg::ST_RUN;
                end
            end
            mcpg_pkg::ST_RUN:
            begin
                if (!out_stall && status.last)
                begin
                    state_next = mcpg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mcpg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            mcpg_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            mcpg_pkg::ST_RUN:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign cmd.load    = in_beat;
    assign cmd.advance = out_beat;

    a_accept_starts_burst: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> out_valid)
        else $error("accepted circle produced no result");

    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_beat && !status.last) |=> out_valid)
        else $error("burst ended before last result");

    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (out_beat && status.last) |=> (!out_valid && !in_stall))
        else $error("block not idle after last result");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken during a burst");

endmodule

`default_nettype wire

### rtl/core/mcpg_datapath.sv
`default_nettype none

module mcpg_datapath #(
    parameter int COORD_BITS  = mcpg_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mcpg_pkg::RADIUS_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire mcpg_pkg::dp_cmd_t                 cmd,
    output mcpg_pkg::dp_status_t                   status,
    input  wire logic [COORD_BITS-1:0]             center_x,
    input  wire logic [COORD_BITS-1:0]             center_y,
    input  wire logic [RADIUS_BITS-1:0]            radius,
    input  wire logic [mcpg_pkg::CHAR_BITS-1:0]    plot_char,
    output logic signed [COORD_BITS+1:0]           pa_x,
    output logic signed [COORD_BITS+1:0]           pa_y,
    output logic signed [COORD_BITS+1:0]           pb_x,
    output logic signed [COORD_BITS+1:0]           pb_y,
    output logic signed [COORD_BITS+1:0]           pc_x,
    output logic signed [COORD_BITS+1:0]           pc_y,
    output logic signed [COORD_BITS+1:0]           pd_x,
    output logic signed [COORD_BITS+1:0]           pd_y,
    output logic [mcpg_pkg::CHAR_BITS-1:0]         point_char,
    output logic                                   last_of_circle
);

    localparam int OW = COORD_BITS + 2;
    localparam int SW = RADIUS_BITS + 2;
    localparam int DW = RADIUS_BITS + 6;

    logic signed [SW-1:0]             x_reg, x_next;
    logic signed [SW-1:0]             y_reg, y_next;
    logic signed [DW-1:0]             d_reg, d_next;
    logic [COORD_BITS-1:0]            cx_reg;
    logic [COORD_BITS-1:0]            cy_reg;
    logic [mcpg_pkg::CHAR_BITS-1:0]   char_reg;
    logic                             phase_reg;
    logic [mcpg_pkg::CNT_W-1:0]       cnt_reg;

    logic signed [DW-1:0]             r_ext;
    logic signed [DW-1:0]             x_ext;
    logic signed [DW-1:0]             y_ext;
    logic signed [OW-1:0]             cx_ext, cy_ext, a_off, b_off;
    logic                             walk_done;

    assign r_ext = signed'(DW'(radius));
    assign x_ext = DW'(x_reg);
    assign y_ext = DW'(y_reg);

    // One walk step: x advances; on positive decision y retreats too.
    // Update terms are written against the old x and y.
    always_comb
    begin
        x_next = x_reg + SW'(1);
        y_next = y_reg;
        if (d_reg > 0)
        begin
            y_next = y_reg - SW'(1);
            d_next = d_reg + ((x_ext - y_ext) <<< 2) + DW'(18);
        end
        else
        begin
            d_next = d_reg + (x_ext <<< 2) + DW'(10);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            y_reg    <= '0;
            d_reg    <= '0;
            cx_reg   <= '0;
            cy_reg   <= '0;
            char_reg <= '0;
        end
        else if (cmd.load)
        begin
            x_reg    <= '0;
            y_reg    <= SW'(r_ext);
            d_reg    <= DW'(3) - (r_ext <<< 1);
            cx_reg   <= center_x;
            cy_reg   <= center_y;
            char_reg <= plot_char;
        end
        else if (cmd.advance && phase_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            d_reg <= d_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (cmd.load)
        begin
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (cmd.advance)
        begin
            phase_reg <= !phase_reg;
            if (phase_reg)
            begin
                cnt_reg <= cnt_reg + mcpg_pkg::CNT_W'(1);
            end
        end
    end

    assign walk_done = (y_reg < x_reg) ||
                       (cnt_reg == mcpg_pkg::CNT_W'(mcpg_pkg::POINT_CAP - 1));

    assign status.last = phase_reg && walk_done;

    // Second beat of a point swaps the roles of x and y.
    assign cx_ext = signed'(OW'(cx_reg));
    assign cy_ext = signed'(OW'(cy_reg));
    assign a_off  = phase_reg ? OW'(y_reg) : OW'(x_reg);
    assign b_off  = phase_reg ? OW'(x_reg) : OW'(y_reg);

    assign pa_x = cx_ext + a_off;
    assign pa_y = cy_ext + b_off;
    assign pb_x = cx_ext - a_off;
    assign pb_y = cy_ext + b_off;
    assign pc_x = cx_ext + a_off;
    assign pc_y = cy_ext - b_off;
    assign pd_x = cx_ext - a_off;
    assign pd_y = cy_ext - b_off;

    assign point_char     = char_reg;
    assign last_of_circle = status.last;

    a_load_clears_phase: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (!phase_reg && cnt_reg == '0))
        else $error("walk not restarted on load");

    a_x_holds_in_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.advance && !phase_reg && !cmd.load) |=> $stable(x_reg))
        else $error("walk moved between the two beats of a point");

    a_cap_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg && cnt_reg == mcpg_pkg::CNT_W'(mcpg_pkg::POINT_CAP - 1)) |-> status.last)
        else $error("result cap not marked last");

endmodule

`default_nettype wire

### rtl/core/midpoint_circle_point_generator.sv
// Midpoint circle outline generator, eight-way symmetry.
// The first result is valid in the cycle after the request beat.
// Each circle yields two results per walk point, at most 24 points; one result
// per cycle from the walk registers while out_stall is low.
// A new request is taken only once the last result of the circle has gone.
// Reset (rst_n low, asynchronous) returns the block to idle with no result pending.
`default_nettype none

module midpoint_circle_point_generator #(
    parameter int COORD_BITS  = mcpg_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mcpg_pkg::RADIUS_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [COORD_BITS-1:0]             center_x,
    input  wire logic [COORD_BITS-1:0]             center_y,
    input  wire logic [RADIUS_BITS-1:0]            radius,
    input  wire logic [mcpg_pkg::CHAR_BITS-1:0]    plot_char,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [COORD_BITS+1:0]           pa_x,
    output logic signed [COORD_BITS+1:0]           pa_y,
    output logic signed [COORD_BITS+1:0]           pb_x,
    output logic signed [COORD_BITS+1:0]           pb_y,
    output logic signed [COORD_BITS+1:0]           pc_x,
    output logic signed [COORD_BITS+1:0]           pc_y,
    output logic signed [COORD_BITS+1:0]           pd_x,
    output logic signed [COORD_BITS+1:0]           pd_y,
    output logic [mcpg_pkg::CHAR_BITS-1:0]         point_char,
    output logic                                   last_of_circle
);

    mcpg_pkg::dp_cmd_t    cmd;
    mcpg_pkg::dp_status_t status;

    mcpg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    mcpg_datapath #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .center_x       (center_x),
        .center_y       (center_y),
        .radius         (radius),
        .plot_char      (plot_char),
        .pa_x           (pa_x),
        .pa_y           (pa_y),
        .pb_x           (pb_x),
        .pb_y           (pb_y),
        .pc_x           (pc_x),
        .pc_y           (pc_y),
        .pd_x           (pd_x),
        .pd_y           (pd_y),
        .point_char     (point_char),
        .last_of_circle (last_of_circle)
    );

endmodule

`default_nettype wire
